FILE: rtl/core/fbct_pkg.sv
// ----------------------------------------------------------------------------
// fbct_pkg
// Types and codes shared by the flow byte counter table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fbct_pkg;

   localparam logic [1:0] REQ_INCOMING = 2'd0;
   localparam logic [1:0] REQ_OUTGOING = 2'd1;
   localparam logic [1:0] REQ_DRAIN    = 2'd2;
   localparam logic [1:0] REQ_UNUSED   = 2'd3;

   localparam logic [2:0] STAT_UPDATED  = 3'd0;
   localparam logic [2:0] STAT_INSERTED = 3'd1;
   localparam logic [2:0] STAT_FULL     = 3'd2;
   localparam logic [2:0] STAT_DRAINED  = 3'd3;
   localparam logic [2:0] STAT_EMPTY    = 3'd4;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] local_address;
      logic [15:0] local_port_num;
      logic [31:0] remote_address;
      logic [15:0] remote_port_num;
      logic [31:0] byte_length;
   } fbct_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_local_address;
      logic [15:0] out_local_port;
      logic [31:0] out_remote_address;
      logic [15:0] out_remote_port;
      logic [63:0] inbound_total;
      logic [63:0] outbound_total;
      logic        last;
   } fbct_rsp_type;

   typedef struct packed {
      logic [31:0] local_addr;
      logic [15:0] local_port;
      logic [31:0] remote_addr;
      logic [15:0] remote_port;
      logic [63:0] in_bytes;
      logic [63:0] out_bytes;
   } fbct_entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_MISS,
      S_UPDATE,
      S_DRAIN_RD,
      S_DRAIN_OUT,
      S_RSP
   } fbct_state_type;

   typedef struct packed {
      logic latch;
      logic idx_inc;
      logic rd;
      logic scan_cmp;
      logic upd_hit;
      logic insert;
      logic full;
      logic empty;
      logic drain_out;
   } fbct_cmd_type;

   typedef struct packed {
      logic [1:0] req_code;
      logic       idx_valid;
      logic       match;
      logic       idx_last;
      logic       free_found;
      logic       table_empty;
      logic       rsp_last;
   } fbct_sts_type;

endpackage

`default_nettype wire

FILE: rtl/core/fbct_ctrl.sv
// ----------------------------------------------------------------------------
// fbct_ctrl
// Sequencer for lookup, insert and drain of the flow table.
// ----------------------------------------------------------------------------
`default_nettype none

module fbct_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic [1:0]            req_code,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire fbct_pkg::fbct_sts_type sts,
   output fbct_pkg::fbct_cmd_type     cmd
);
   import fbct_pkg::*;

   fbct_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_RSP);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               unique case (req_code)
                  REQ_INCOMING, REQ_OUTGOING: state_in = S_SCAN_RD;
                  REQ_DRAIN: begin
                     if (sts.table_empty) begin
                        cmd.empty = 1'b1;
                        state_in  = S_RSP;
                     end else begin
                        state_in = S_DRAIN_RD;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            if (sts.match) begin
               state_in = S_UPDATE;
            end else if (sts.idx_last) begin
               state_in = S_MISS;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         S_MISS: begin
            if (sts.free_found) begin
               cmd.insert = 1'b1;
            end else begin
               cmd.full = 1'b1;
            end
            state_in = S_RSP;
         end
         S_UPDATE: begin
            cmd.upd_hit = 1'b1;
            state_in    = S_RSP;
         end
         S_DRAIN_RD: begin
            if (sts.idx_valid) begin
               cmd.rd   = 1'b1;
               state_in = S_DRAIN_OUT;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_DRAIN_OUT: begin
            cmd.drain_out = 1'b1;
            state_in      = S_RSP;
         end
         S_RSP: begin
            if (!rsp_stall) begin
               if (sts.req_code == REQ_DRAIN && !sts.rsp_last) begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_DRAIN_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/fbct_datapath.sv
// ----------------------------------------------------------------------------
// fbct_datapath
// Entry memory, valid bits, scan index, counter update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fbct_datapath #(
   parameter int FLOW_ENTRIES = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fbct_pkg::fbct_req_type req_data,
   input  wire fbct_pkg::fbct_cmd_type cmd,
   output fbct_pkg::fbct_sts_type     sts,
   output fbct_pkg::fbct_rsp_type     rsp_data
);
   import fbct_pkg::*;

   localparam int IDX_W = $clog2(FLOW_ENTRIES);

   fbct_entry_type             entry_mem_ff [FLOW_ENTRIES];
   fbct_entry_type             rd_ff;
   fbct_req_type               req_ff;
   fbct_rsp_type               rsp_ff, rsp_in;
   logic [FLOW_ENTRIES-1:0]    valid_ff, valid_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [IDX_W-1:0]           free_ff, free_in;
   logic                       free_found_ff, free_found_in;
   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   fbct_entry_type             wr_data;
   fbct_entry_type             upd_entry;
   logic [FLOW_ENTRIES-1:0]    above;
   logic                       key_eq;

   assign key_eq = (rd_ff.local_addr == req_ff.local_address) &&
                   (rd_ff.local_port == req_ff.local_port_num) &&
                   (rd_ff.remote_addr == req_ff.remote_address) &&
                   (rd_ff.remote_port == req_ff.remote_port_num);

   assign above = valid_ff &
                  ~(({{(FLOW_ENTRIES-1){1'b0}}, 1'b1} << idx_ff << 1) -
                    {{(FLOW_ENTRIES-1){1'b0}}, 1'b1});

   always_comb begin
      upd_entry = rd_ff;
      if (req_ff.req_type == REQ_INCOMING) begin
         upd_entry.in_bytes = rd_ff.in_bytes + {32'b0, req_ff.byte_length};
      end else begin
         upd_entry.out_bytes = rd_ff.out_bytes + {32'b0, req_ff.byte_length};
      end
   end

   always_comb begin
      idx_in        = idx_ff;
      free_in       = free_ff;
      free_found_in = free_found_ff;
      valid_in      = valid_ff;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = upd_entry;
      if (cmd.latch) begin
         idx_in        = '0;
         free_found_in = 1'b0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.scan_cmp && !valid_ff[idx_ff] && !free_found_ff) begin
         free_in       = idx_ff;
         free_found_in = 1'b1;
      end
      if (cmd.upd_hit) begin
         wr_en  = 1'b1;
         rsp_in = '{STAT_UPDATED, upd_entry.local_addr, upd_entry.local_port,
                    upd_entry.remote_addr, upd_entry.remote_port,
                    upd_entry.in_bytes, upd_entry.out_bytes, 1'b1};
      end
      if (cmd.insert) begin
         wr_en   = 1'b1;
         wr_addr = free_ff;
         wr_data.local_addr  = req_ff.local_address;
         wr_data.local_port  = req_ff.local_port_num;
         wr_data.remote_addr = req_ff.remote_address;
         wr_data.remote_port = req_ff.remote_port_num;
         wr_data.in_bytes    = (req_ff.req_type == REQ_INCOMING) ?
                               {32'b0, req_ff.byte_length} : 64'b0;
         wr_data.out_bytes   = (req_ff.req_type == REQ_INCOMING) ?
                               64'b0 : {32'b0, req_ff.byte_length};
         valid_in[free_ff]   = 1'b1;
         rsp_in = '{STAT_INSERTED, wr_data.local_addr, wr_data.local_port,
                    wr_data.remote_addr, wr_data.remote_port,
                    wr_data.in_bytes, wr_data.out_bytes, 1'b1};
      end
      if (cmd.full) begin
         rsp_in = '{STAT_FULL, req_ff.local_address, req_ff.local_port_num,
                    req_ff.remote_address, req_ff.remote_port_num,
                    64'b0, 64'b0, 1'b1};
      end
      if (cmd.empty) begin
         rsp_in = '{STAT_EMPTY, 32'b0, 16'b0, 32'b0, 16'b0, 64'b0, 64'b0, 1'b1};
      end
      if (cmd.drain_out) begin
         valid_in[idx_ff] = 1'b0;
         rsp_in = '{STAT_DRAINED, rd_ff.local_addr, rd_ff.local_port,
                    rd_ff.remote_addr, rd_ff.remote_port,
                    rd_ff.in_bytes, rd_ff.out_bytes, ~|above};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         free_found_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         valid_ff      <= valid_in;
         free_found_ff <= free_found_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      free_ff <= free_in;
      rsp_ff  <= rsp_in;
      if (cmd.latch) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_ff <= entry_mem_ff[idx_ff];
      end
   end

   assign sts.req_code    = req_ff.req_type;
   assign sts.idx_valid   = valid_ff[idx_ff];
   assign sts.match       = valid_ff[idx_ff] && key_eq;
   assign sts.idx_last    = (idx_ff == IDX_W'(FLOW_ENTRIES - 1));
   assign sts.free_found  = free_found_ff;
   assign sts.table_empty = ~|valid_ff;
   assign sts.rsp_last    = rsp_ff.last;
   assign rsp_data        = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/core/flow_byte_counter_table_top.sv
// ----------------------------------------------------------------------------
// flow_byte_counter_table_top
// Per-flow inbound/outbound byte counter table with drain and clear.
// ----------------------------------------------------------------------------
//  channel  direction  ports                            transfer
//  req      in         req_valid, req_stall, req_data   valid && !stall
//  rsp      out        rsp_valid, rsp_stall, rsp_data   valid && !stall
//
//  One item at a time. A report scans the entry memory slot by slot, a read
//  then a compare, up to the hit or through all FLOW_ENTRIES slots on a miss,
//  then writes the updated or inserted entry (none when full), then gives the
//  result. A drain gives one result per valid entry. Reset clears the valid
//  bits but not the entry memory.
//  rsp_stall holds the result register and the next request waits.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_byte_counter_table_top #(
   parameter int FLOW_ENTRIES = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire fbct_pkg::fbct_req_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output fbct_pkg::fbct_rsp_type     rsp_data
);
   import fbct_pkg::*;

   fbct_cmd_type cmd;
   fbct_sts_type sts;

   fbct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_code  (req_data.req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fbct_datapath #(
      .FLOW_ENTRIES (FLOW_ENTRIES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives flow reports and drains into the flow byte counter table, predicts
// every result from a local copy of the table and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fbct_pkg::*;

   localparam int ENTRIES = 64;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   fbct_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   fbct_rsp_type rsp_data;

   fbct_req_type pending_reqs[$];
   fbct_rsp_type expected_rsps[$];

   logic           slot_used[ENTRIES];
   fbct_entry_type slot_data[ENTRIES];

   int mismatches = 0;
   int cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   int stall_phase = 0;
   bit hold_request = 1'b0;

   // small key pool so that hits, inserts and a full table all occur
   logic [31:0] key_la[96];
   logic [15:0] key_lp[96];
   logic [31:0] key_ra[96];
   logic [15:0] key_rp[96];

   flow_byte_counter_table_top #(.FLOW_ENTRIES(ENTRIES)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   function automatic fbct_rsp_type make_rsp(logic [2:0] st, fbct_entry_type e,
                                             logic lst);
      fbct_rsp_type r;
      r.status = st;
      r.out_local_address = e.local_addr;
      r.out_local_port = e.local_port;
      r.out_remote_address = e.remote_addr;
      r.out_remote_port = e.remote_port;
      r.inbound_total = e.in_bytes;
      r.outbound_total = e.out_bytes;
      r.last = lst;
      return r;
   endfunction

   task automatic account_flow(fbct_req_type q);
      int hit;
      int free_slot;
      int last_slot;
      fbct_entry_type e;
      hit = -1;
      free_slot = -1;
      last_slot = -1;
      if (q.req_type == REQ_UNUSED) return;
      if (q.req_type == REQ_DRAIN) begin
         for (int i = 0; i < ENTRIES; i++) if (slot_used[i]) last_slot = i;
         if (last_slot < 0) begin
            expected_rsps.push_back(make_rsp(STAT_EMPTY, '0, 1'b1));
            return;
         end
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i]) begin
               expected_rsps.push_back(make_rsp(STAT_DRAINED, slot_data[i],
                                                i == last_slot));
               slot_used[i] = 1'b0;
            end
         end
         return;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_used[i]) begin
            if (hit < 0 && slot_data[i].local_addr == q.local_address &&
                slot_data[i].local_port == q.local_port_num &&
                slot_data[i].remote_addr == q.remote_address &&
                slot_data[i].remote_port == q.remote_port_num) hit = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (hit >= 0) begin
         if (q.req_type == REQ_INCOMING)
            slot_data[hit].in_bytes += {32'd0, q.byte_length};
         else slot_data[hit].out_bytes += {32'd0, q.byte_length};
         expected_rsps.push_back(make_rsp(STAT_UPDATED, slot_data[hit], 1'b1));
         return;
      end
      e.local_addr = q.local_address;
      e.local_port = q.local_port_num;
      e.remote_addr = q.remote_address;
      e.remote_port = q.remote_port_num;
      e.in_bytes = '0;
      e.out_bytes = '0;
      if (free_slot < 0) begin
         expected_rsps.push_back(make_rsp(STAT_FULL, e, 1'b1));
         return;
      end
      if (q.req_type == REQ_INCOMING) e.in_bytes = {32'd0, q.byte_length};
      else e.out_bytes = {32'd0, q.byte_length};
      slot_used[free_slot] = 1'b1;
      slot_data[free_slot] = e;
      expected_rsps.push_back(make_rsp(STAT_INSERTED, e, 1'b1));
   endtask

   task automatic queue_req(logic [1:0] kind, logic [31:0] la, logic [15:0] lp,
                            logic [31:0] ra, logic [15:0] rp, logic [31:0] len);
      fbct_req_type q;
      q.req_type = kind;
      q.local_address = la;
      q.local_port_num = lp;
      q.remote_address = ra;
      q.remote_port_num = rp;
      q.byte_length = len;
      pending_reqs.push_back(q);
   endtask

   task automatic queue_pool(logic [1:0] kind, int k, logic [31:0] len);
      queue_req(kind, key_la[k], key_lp[k], key_ra[k], key_rp[k], len);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            account_flow(req_data);
            void'(pending_reqs.pop_front());
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= pending_reqs[0];
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 20);
               if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, with a long hold-off on request
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (hold_request && hold_left == 0) begin
         hold_left <= 3000;
         hold_request <= 1'b0;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left != 1);
      end else if (stall_phase % 512 < 128) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      fbct_rsp_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected transfer %p", rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.out_local_address !== want.out_local_address ||
                rsp_data.out_local_port !== want.out_local_port ||
                rsp_data.out_remote_address !== want.out_remote_address ||
                rsp_data.out_remote_port !== want.out_remote_port ||
                rsp_data.inbound_total !== want.inbound_total ||
                rsp_data.outbound_total !== want.outbound_total ||
                rsp_data.last !== want.last) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: expected %p actual %p", want, rsp_data);
            end
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int k;
      int r;
      for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
      for (int i = 0; i < 96; i++) begin
         key_la[i] = $urandom;
         key_lp[i] = 16'($urandom);
         key_ra[i] = $urandom;
         key_rp[i] = 16'($urandom);
      end
      key_la[0] = '1; key_lp[0] = '1; key_ra[0] = '1; key_rp[0] = '1;
      key_la[1] = '0; key_lp[1] = '0; key_ra[1] = '0; key_rp[1] = '0;
      // keys differing in one field only
      key_la[2] = '1; key_lp[2] = '1; key_ra[2] = '1; key_rp[2] = 16'hfffe;
      key_la[3] = 32'h7fffffff; key_lp[3] = '1; key_ra[3] = '1; key_rp[3] = '1;

      // directed
      queue_req(REQ_DRAIN, '1, '1, '1, '1, '1);
      queue_pool(REQ_INCOMING, 0, '1);
      queue_pool(REQ_OUTGOING, 1, 32'd0);
      queue_pool(REQ_INCOMING, 2, 32'd5);
      queue_pool(REQ_OUTGOING, 3, '1);
      queue_pool(REQ_INCOMING, 0, '1);
      queue_pool(REQ_OUTGOING, 0, '1);
      queue_req(REQ_UNUSED, '1, '1, '1, '1, '1);
      queue_pool(REQ_OUTGOING, 1, 32'd7);
      queue_req(REQ_DRAIN, 32'h1234, 16'h5, 32'h6, 16'h7, 32'h8);
      queue_req(REQ_DRAIN, '0, '0, '0, '0, '0);
      // fill the table, overflow, carry a total into its upper word
      for (int i = 0; i < ENTRIES + 3; i++) queue_pool(REQ_INCOMING, i, '1);
      for (int i = 0; i < 6; i++) queue_pool(REQ_INCOMING, 5, '1);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // long wrap: drive one entry's total past 2^64 is not reachable; check
      // carries into the upper word instead (done above). Now hold off output.
      hold_request <= 1'b1;

      for (int n = 0; n < 220; n++) begin
         r = $urandom_range(0, 99);
         k = (n < 110) ? $urandom_range(0, 20) : $urandom_range(0, 95);
         if (r < 4) queue_req(REQ_DRAIN, $urandom, 16'($urandom), $urandom,
                              16'($urandom), $urandom);
         else if (r < 6) queue_req(REQ_UNUSED, $urandom, 16'($urandom), $urandom,
                                   16'($urandom), $urandom);
         else if (r < 10) queue_req(2'($urandom_range(0, 1)), $urandom,
                                    16'($urandom), $urandom, 16'($urandom),
                                    $urandom);
         else queue_pool(r[0] ? REQ_OUTGOING : REQ_INCOMING, k,
                         (r < 20) ? $urandom_range(0, 3) : $urandom);
      end
      queue_req(REQ_DRAIN, '0, '0, '0, '0, '0);

      while (pending_reqs.size() != 0) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
